// ===== rtl/txc_pkg.sv =====
// Shared constants and types for the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package txc_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam int ENTRY_W = 16;
  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int NIB_W   = 4;
  localparam int RCOL_W  = 7;
  localparam int RROW_W  = 5;
  localparam int ATTR_W  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

endpackage
`default_nettype wire

// ===== rtl/txc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/text_console_writer_top.sv =====
// Text console writer: screen cell store, cursor and attribute sequencer.
//
// A COLS x ROWS screen of 16-bit cells (attribute high byte, character low
// byte) in one RAM, driven by a small sequencer around a single cell
// address counter. After reset the block runs a clearing pass over every
// cell with in_ready low. Items are taken one at a time; the result goes
// to an output register, so the next item can be taken while the result
// waits. An ordinary character writes its cell and a newline only moves the
// cursor; an item that moves the cursor past the last row first scrolls,
// walking the RAM copy port to move every row up by one and then blanking
// the bottom row; set color rewrites the attribute of every cell; clear
// screen blanks every cell; reading a cell waits on the registered RAM read
// data. The single RAM port pair handles one cell per cycle.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_top #(
  parameter int COLS = txc_pkg::COLS_DEF,
  parameter int ROWS = txc_pkg::ROWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [txc_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [txc_pkg::CHAR_W-1:0]   in_char_code,
  input  wire logic [txc_pkg::NIB_W-1:0]    in_fg_color,
  input  wire logic [txc_pkg::NIB_W-1:0]    in_bg_color,
  input  wire logic [txc_pkg::RCOL_W-1:0]   in_read_col,
  input  wire logic [txc_pkg::RROW_W-1:0]   in_read_row,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [txc_pkg::ENTRY_W-1:0]  out_read_entry,
  output logic      [txc_pkg::RCOL_W-1:0]   out_cursor_col_out,
  output logic      [txc_pkg::RROW_W-1:0]   out_cursor_row_out,
  output logic      [txc_pkg::ATTR_W-1:0]   out_color_out
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(COLS + 1);
  localparam int ROW_W = $clog2(ROWS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCROLL,
    S_BLANK,
    S_PUT,
    S_RECOLOR,
    S_RDREQ,
    S_RDWAIT
  } state_t;

  // S_DONE folded into a pending flag: result waits for the output register
  state_t state_r, state_nxt;
  logic   done_r, done_nxt;
  logic   gen_r, gen_nxt;

  logic [IW-1:0]    idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    widx_r, widx_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [txc_pkg::ATTR_W-1:0]  attr_r, attr_nxt;
  logic [txc_pkg::CHAR_W-1:0]  ch_r, ch_nxt;
  logic [txc_pkg::RCOL_W-1:0]  rc_r, rc_nxt;
  logic [txc_pkg::RROW_W-1:0]  rr_r, rr_nxt;
  logic [txc_pkg::ENTRY_W-1:0] entry_r, entry_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [txc_pkg::ENTRY_W-1:0] out_entry_r;
  logic [txc_pkg::RCOL_W-1:0]  out_col_r;
  logic [txc_pkg::RROW_W-1:0]  out_row_r;
  logic [txc_pkg::ATTR_W-1:0]  out_attr_r;
  logic                        out_load;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [txc_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic             accept;
  logic [AW-1:0]    put_addr, rd_addr;
  logic             rd_in_range;
  logic             wrap;
  logic [ROW_W-1:0] wrap_row;
  txc_pkg::mode_t   in_mode_e;

  assign in_ready  = (state_r == S_IDLE) && !done_r;
  assign accept    = in_valid && in_ready;
  assign in_mode_e = txc_pkg::mode_t'(in_mode);

  assign put_addr = AW'(AW'(row_r) * AW'(COLS) + AW'(col_r));
  assign rd_addr  = AW'(AW'(rr_r) * AW'(COLS) + AW'(rc_r));
  assign rd_in_range = (int'(rc_r) < COLS) && (int'(rr_r) < ROWS);

  assign wrap     = (in_char_code == txc_pkg::NEWLINE_CHAR) || (int'(col_r) >= COLS);
  assign wrap_row = ROW_W'(row_r + 1'b1);

  assign out_load = done_r && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    gen_nxt   = gen_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    widx_nxt  = idx_r[AW-1:0];
    col_nxt   = col_r;
    row_nxt   = row_r;
    attr_nxt  = attr_r;
    ch_nxt    = ch_r;
    rc_nxt    = rc_r;
    rr_nxt    = rr_r;
    entry_nxt = entry_r;
    ram_we    = 1'b0;
    ram_waddr = widx_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];

    if (out_load) begin
      done_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = {txc_pkg::RESET_ATTR, txc_pkg::BLANK_CHAR};
        idx_nxt   = IW'(idx_r + 1'b1);
        if (idx_r == IW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
          done_nxt  = gen_r;
        end
      end

      S_IDLE: begin
        if (accept) begin
          gen_nxt   = 1'b1;
          ch_nxt    = in_char_code;
          rc_nxt    = in_read_col;
          rr_nxt    = in_read_row;
          entry_nxt = '0;
          idx_nxt   = '0;
          unique case (in_mode_e)
            txc_pkg::MODE_PUT: begin
              if (wrap) begin
                col_nxt = '0;
                if (int'(wrap_row) >= ROWS) begin
                  row_nxt   = ROW_W'(ROWS - 1);
                  state_nxt = S_SCROLL;
                end else begin
                  row_nxt   = wrap_row;
                  state_nxt = S_PUT;
                end
              end else begin
                state_nxt = S_PUT;
              end
            end
            txc_pkg::MODE_COLOR: begin
              attr_nxt  = {in_bg_color, in_fg_color};
              state_nxt = S_RECOLOR;
            end
            txc_pkg::MODE_CLEAR: begin
              attr_nxt  = txc_pkg::RESET_ATTR;
              col_nxt   = '0;
              row_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            txc_pkg::MODE_READ: begin
              state_nxt = S_RDREQ;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // read row below, write the registered read data one row up
      S_SCROLL: begin
        ram_we = pend_r;
        if (idx_r < IW'(CELLS - COLS)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r + IW'(COLS));
          pend_nxt  = 1'b1;
          idx_nxt   = IW'(idx_r + 1'b1);
        end else begin
          state_nxt = S_BLANK;
        end
      end

      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = {attr_r, txc_pkg::BLANK_CHAR};
        idx_nxt   = IW'(idx_r + 1'b1);
        if (idx_r == IW'(CELLS - 1)) begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        if (ch_r != txc_pkg::NEWLINE_CHAR) begin
          ram_we    = 1'b1;
          ram_waddr = put_addr;
          ram_wdata = {attr_r, ch_r};
          col_nxt   = COL_W'(col_r + 1'b1);
        end
        state_nxt = S_IDLE;
        done_nxt  = 1'b1;
      end

      S_RECOLOR: begin
        ram_we    = pend_r;
        ram_wdata = {attr_r, ram_rdata[txc_pkg::CHAR_W-1:0]};
        if (idx_r < IW'(CELLS)) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          idx_nxt  = IW'(idx_r + 1'b1);
        end else begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end
      end

      S_RDREQ: begin
        ram_re    = 1'b1;
        ram_raddr = rd_addr;
        state_nxt = S_RDWAIT;
      end

      S_RDWAIT: begin
        entry_nxt = rd_in_range ? ram_rdata : '0;
        state_nxt = S_IDLE;
        done_nxt  = 1'b1;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      done_r      <= 1'b0;
      gen_r       <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= txc_pkg::RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      gen_r       <= gen_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    widx_r  <= widx_nxt;
    ch_r    <= ch_nxt;
    rc_r    <= rc_nxt;
    rr_r    <= rr_nxt;
    entry_r <= entry_nxt;
    if (out_load) begin
      out_entry_r <= entry_r;
      out_col_r   <= txc_pkg::RCOL_W'(col_r);
      out_row_r   <= txc_pkg::RROW_W'(row_r);
      out_attr_r  <= attr_r;
    end
  end

  txc_ram #(
    .WIDTH (txc_pkg::ENTRY_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_read_entry     = out_entry_r;
  assign out_cursor_col_out = out_col_r;
  assign out_cursor_row_out = out_row_r;
  assign out_color_out      = out_attr_r;

endmodule
`default_nettype wire

// ===== rtl/txc_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module txc_checker #(
  parameter int COLS = txc_pkg::COLS_DEF,
  parameter int ROWS = txc_pkg::ROWS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [txc_pkg::MODE_W-1:0]  in_mode,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [txc_pkg::ENTRY_W-1:0] out_read_entry,
  input wire logic [txc_pkg::RCOL_W-1:0]  out_cursor_col_out,
  input wire logic [txc_pkg::RROW_W-1:0]  out_cursor_row_out,
  input wire logic [txc_pkg::ATTR_W-1:0]  out_color_out
);

  // one item in flight: busy right after each accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  // cursor stays on screen; column may sit at COLS when the line is full
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_col_out) <= COLS) && (int'(out_cursor_row_out) < ROWS))
    else $error("cursor off screen");

  // clear walks the whole screen: no result beat right after the accepted clear
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == txc_pkg::MODE_CLEAR) && !out_valid) |=>
      !out_valid [*2])
    else $error("clear result appeared too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_read_entry) &&
      $stable(out_cursor_col_out) && $stable(out_cursor_row_out) && $stable(out_color_out))
    else $error("result beat changed while stalled");

endmodule

bind text_console_writer_top txc_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_txc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_mode            (in_mode),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_read_entry     (out_read_entry),
  .out_cursor_col_out (out_cursor_col_out),
  .out_cursor_row_out (out_cursor_row_out),
  .out_color_out      (out_color_out)
);
`default_nettype wire

// ===== test/tb_text_console_writer_top.sv =====
// Self-checking testbench for the text console writer: screen, cursor and color behavior.
`timescale 1ns / 1ps
module tb_text_console_writer_top;

  localparam int COLS      = txc_pkg::COLS_DEF;
  localparam int ROWS      = txc_pkg::ROWS_DEF;
  localparam int CELLS     = COLS * ROWS;
  localparam int RAND_CMDS = 1200;
  localparam int NL_CODE   = int'(txc_pkg::NEWLINE_CHAR);
  localparam int SP_CODE   = int'(txc_pkg::BLANK_CHAR);
  // a full-screen walk plus margin
  localparam int TAIL_CYCLES = CELLS + 64;

  typedef struct {
    txc_pkg::mode_t             mode;
    logic [txc_pkg::CHAR_W-1:0] ch;
    logic [txc_pkg::NIB_W-1:0]  fg;
    logic [txc_pkg::NIB_W-1:0]  bg;
    logic [txc_pkg::RCOL_W-1:0] rcol;
    logic [txc_pkg::RROW_W-1:0] rrow;
  } console_cmd_t;

  typedef struct {
    logic [txc_pkg::ENTRY_W-1:0] entry;
    logic [txc_pkg::RCOL_W-1:0]  col;
    logic [txc_pkg::RROW_W-1:0]  row;
    logic [txc_pkg::ATTR_W-1:0]  attr;
  } console_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [txc_pkg::MODE_W-1:0] in_mode = '0;
  logic [txc_pkg::CHAR_W-1:0] in_char_code = '0;
  logic [txc_pkg::NIB_W-1:0]  in_fg_color = '0;
  logic [txc_pkg::NIB_W-1:0]  in_bg_color = '0;
  logic [txc_pkg::RCOL_W-1:0] in_read_col = '0;
  logic [txc_pkg::RROW_W-1:0] in_read_row = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [txc_pkg::ENTRY_W-1:0] out_read_entry;
  logic [txc_pkg::RCOL_W-1:0]  out_cursor_col_out;
  logic [txc_pkg::RROW_W-1:0]  out_cursor_row_out;
  logic [txc_pkg::ATTR_W-1:0]  out_color_out;

  // shadow of the console state
  logic [txc_pkg::ENTRY_W-1:0] screen [0:CELLS-1];
  int unsigned                 cur_col;
  int unsigned                 cur_row;
  logic [txc_pkg::ATTR_W-1:0]  cur_attr;

  console_cmd_t  cmd_q[$];
  console_view_t view_q[$];
  console_cmd_t  cur_cmd;
  int            n_queued = 0;
  int            n_accepted = 0;
  int            n_fail = 0;
  logic          steady = 1'b0;

  text_console_writer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_char_code       (in_char_code),
    .in_fg_color        (in_fg_color),
    .in_bg_color        (in_bg_color),
    .in_read_col        (in_read_col),
    .in_read_row        (in_read_row),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_entry     (out_read_entry),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cursor_row_out (out_cursor_row_out),
    .out_color_out      (out_color_out)
  );

  always #5 clk = ~clk;

  task automatic console_clear();
    cur_attr = txc_pkg::RESET_ATTR;
    cur_col  = 0;
    cur_row  = 0;
    for (int i = 0; i < CELLS; i++) screen[i] = {txc_pkg::RESET_ATTR, txc_pkg::BLANK_CHAR};
  endtask

  task automatic console_step(input console_cmd_t c, output console_view_t v);
    v.entry = '0;
    case (c.mode)
      txc_pkg::MODE_PUT: begin
        // late wrap: a full line only moves on when the next char shows up
        if (c.ch == txc_pkg::NEWLINE_CHAR || cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i + COLS < CELLS; i++) screen[i] = screen[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {cur_attr, txc_pkg::BLANK_CHAR};
          if (cur_row > 0) cur_row--;
        end
        if (c.ch != txc_pkg::NEWLINE_CHAR) begin
          if (cur_row < ROWS && cur_col < COLS)
            screen[cur_row * COLS + cur_col] = {cur_attr, c.ch};
          cur_col++;
        end
      end
      txc_pkg::MODE_COLOR: begin
        cur_attr = {c.bg, c.fg};
        for (int i = 0; i < CELLS; i++)
          screen[i] = {cur_attr, screen[i][txc_pkg::CHAR_W-1:0]};
      end
      txc_pkg::MODE_CLEAR: begin
        console_clear();
      end
      default: begin
        if (c.rcol < COLS && c.rrow < ROWS) v.entry = screen[c.rrow * COLS + c.rcol];
      end
    endcase
    v.col  = cur_col[txc_pkg::RCOL_W-1:0];
    v.row  = cur_row[txc_pkg::RROW_W-1:0];
    v.attr = cur_attr;
  endtask

  // negative field values are filled at random
  task automatic queue_cmd(input txc_pkg::mode_t m, input int ch, input int fg, input int bg,
                           input int rc, input int rr);
    console_cmd_t c;
    c.mode = m;
    c.ch   = (ch < 0) ? txc_pkg::CHAR_W'($urandom_range(0, 255)) : txc_pkg::CHAR_W'(ch);
    c.fg   = (fg < 0) ? txc_pkg::NIB_W'($urandom_range(0, 15)) : txc_pkg::NIB_W'(fg);
    c.bg   = (bg < 0) ? txc_pkg::NIB_W'($urandom_range(0, 15)) : txc_pkg::NIB_W'(bg);
    c.rcol = (rc < 0) ? txc_pkg::RCOL_W'($urandom_range(0, 127)) : txc_pkg::RCOL_W'(rc);
    c.rrow = (rr < 0) ? txc_pkg::RROW_W'($urandom_range(0, 31)) : txc_pkg::RROW_W'(rr);
    cmd_q.push_back(c);
    n_queued++;
  endtask

  function automatic int text_char();
    int c;
    c = int'($urandom_range(0, 255));
    if (c == NL_CODE) c = SP_CODE;
    return c;
  endfunction

  task automatic queue_line(input int len);
    for (int i = 0; i < len; i++) queue_cmd(txc_pkg::MODE_PUT, text_char(), -1, -1, -1, -1);
  endtask

  task automatic queue_reads(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, -1, -1);
      else
        queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, int'($urandom_range(0, COLS - 1)),
                  int'($urandom_range(0, ROWS - 1)));
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || view_q.size() != 0) @(negedge clk);
  endtask

  // input side
  always @(posedge clk) begin : drive_beats
    logic          take;
    console_view_t v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        console_step(cur_cmd, v);
        view_q.push_back(v);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        take = cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= 9);
        if (take) begin
          cur_cmd = cmd_q.pop_front();
          in_mode      <= cur_cmd.mode;
          in_char_code <= cur_cmd.ch;
          in_fg_color  <= cur_cmd.fg;
          in_bg_color  <= cur_cmd.bg;
          in_read_col  <= cur_cmd.rcol;
          in_read_row  <= cur_cmd.rrow;
        end
        in_valid <= take;
      end
      steady <= n_accepted >= 400 && n_accepted < 700;
    end
  end

  // result side
  always @(posedge clk) begin : check_beats
    console_view_t exp_v;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (view_q.size() == 0) begin
          $error("result beat with nothing expected");
          n_fail++;
        end else begin
          exp_v = view_q.pop_front();
          if (out_read_entry !== exp_v.entry) begin
            $error("read_entry expected %h got %h", exp_v.entry, out_read_entry);
            n_fail++;
          end
          if (out_cursor_col_out !== exp_v.col) begin
            $error("cursor_col_out expected %0d got %0d", exp_v.col, out_cursor_col_out);
            n_fail++;
          end
          if (out_cursor_row_out !== exp_v.row) begin
            $error("cursor_row_out expected %0d got %0d", exp_v.row, out_cursor_row_out);
            n_fail++;
          end
          if (out_color_out !== exp_v.attr) begin
            $error("color_out expected %h got %h", exp_v.attr, out_color_out);
            n_fail++;
          end
        end
      end
      out_ready <= steady || $urandom_range(0, 99) >= 9;
    end
  end

  initial begin
    #100_000_000;
    $display("text_console_writer_top verification failed");
    $finish;
  end

  initial begin : stimulus
    int start;
    int r;
    console_clear();
    // reset screen, corners and out-of-range reads, then puts, colors and a clear
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 0, 0);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, COLS - 1, ROWS - 1);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, COLS, 0);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 0, ROWS);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 127, 31);
    queue_cmd(txc_pkg::MODE_PUT, 'h41, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_PUT, 'hFF, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_PUT, 'h00, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_PUT, NL_CODE, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_PUT, SP_CODE, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_COLOR, -1, 0, 0, -1, -1);
    queue_cmd(txc_pkg::MODE_COLOR, -1, 15, 15, -1, -1);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 0, 0);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 1, 0);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 0, 1);
    queue_cmd(txc_pkg::MODE_CLEAR, -1, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 0, 0);
    queue_cmd(txc_pkg::MODE_COLOR, -1, 5, 10, -1, -1);
    queue_cmd(txc_pkg::MODE_PUT, 'h80, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_PUT, 'h7F, -1, -1, -1, -1);
    queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, 1, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // hold the sender until the pipe is empty
    wait_drained();

    start = n_queued;
    // newline on a full line, late wrap, scroll past the bottom, then bottom-row reads
    queue_line(COLS);
    queue_cmd(txc_pkg::MODE_PUT, NL_CODE, -1, -1, -1, -1);
    queue_line(COLS);
    queue_cmd(txc_pkg::MODE_PUT, text_char(), -1, -1, -1, -1);
    for (int i = 0; i < ROWS + 1; i++) queue_cmd(txc_pkg::MODE_PUT, NL_CODE, -1, -1, -1, -1);
    queue_line(3);
    for (int i = 0; i < 4; i++)
      queue_cmd(txc_pkg::MODE_READ, -1, -1, -1, int'($urandom_range(0, COLS - 1)),
                ROWS - 1 - i);

    while (n_queued - start < RAND_CMDS) begin
      r = int'($urandom_range(0, 99));
      if (r < 35) begin
        queue_line(int'($urandom_range(1, 40)));
        if ($urandom_range(0, 1)) queue_cmd(txc_pkg::MODE_PUT, NL_CODE, -1, -1, -1, -1);
      end else if (r < 45) begin
        queue_line(COLS);
        if ($urandom_range(0, 1))
          queue_cmd(txc_pkg::MODE_PUT, NL_CODE, -1, -1, -1, -1);
        else
          queue_cmd(txc_pkg::MODE_PUT, text_char(), -1, -1, -1, -1);
      end else if (r < 60) begin
        for (int i = int'($urandom_range(1, 8)); i > 0; i--)
          queue_cmd(txc_pkg::MODE_PUT, NL_CODE, -1, -1, -1, -1);
      end else if (r < 85) begin
        queue_reads(int'($urandom_range(1, 4)));
      end else if (r < 95) begin
        queue_cmd(txc_pkg::MODE_COLOR, -1, -1, -1, -1, -1);
      end else begin
        queue_cmd(txc_pkg::MODE_CLEAR, -1, -1, -1, -1, -1);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (view_q.size() != 0) begin
      $error("%0d expected results never arrived", view_q.size());
      n_fail++;
    end
    if (n_fail == 0)
      $display("text_console_writer_top verification clean");
    else
      $display("text_console_writer_top verification failed");
    $finish;
  end

endmodule
